// ----- rtl/sutset_pkg.sv -----
// sutset_pkg: shared types, codes and default sizes for the sorted time set
// request/response structs, status codes, controller states and cell control
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sutset_pkg;

    // default sizes
    localparam int DEF_SET_DEPTH = 64;
    localparam int DEF_TIME_BITS = 31;

    // fixed field widths of the item interface
    localparam int FLD_TIME_W   = 31;
    localparam int FLD_COUNT_W  = 7;
    localparam int FLD_STATUS_W = 3;

    // request opcodes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // response status codes
    typedef enum logic [FLD_STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY,
        S_DONE
    } t_state;

    // input item
    typedef struct packed {
        logic                  func;
        logic [FLD_TIME_W-1:0] time_value;
    } t_req;

    // result item
    typedef struct packed {
        t_status                status;
        logic [FLD_TIME_W-1:0]  earliest_time;
        logic [FLD_COUNT_W-1:0] entry_count;
        logic                   is_empty;
    } t_rsp;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic flag_en;  // register compare flags against the request time
        logic ins_en;   // open a gap and place the new time
        logic del_en;   // close the gap over the matched time
    } t_cell_ctl;

endpackage : sutset_pkg

`default_nettype wire

// ----- rtl/sorted_unique_time_set.sv -----
// sorted_unique_time_set: ascending set of distinct times in a chain of cells
// channel     | ports                   | timing
// request     | start, busy, i_req      | taken when start is high and busy low
// response    | o_done, o_rsp           | o_done high for one cycle, no back-pressure
// after acceptance each item passes through S_CMP, in which every cell compares
// its time, S_APPLY, in which the chain shifts by a slot on a successful insert
// or delete, and S_DONE, showing the result; then busy drops again
// synchronous active-low reset empties the set; stored times need no clearing
// the response cannot be stalled, so no item is ever held back on that side
// depends on sutset_pkg, sutset_cell, sutset_ctrl
`timescale 1ns / 1ps
`default_nettype none

module sorted_unique_time_set
    import sutset_pkg::*;
#(
    parameter int SET_DEPTH = DEF_SET_DEPTH,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_done,
    output t_rsp      o_rsp
);

    localparam int CW = $clog2(SET_DEPTH + 1);

    logic                 r_func;
    logic [TIME_BITS-1:0] r_t;
    logic [TIME_BITS+FLD_TIME_W-1:0] w_t_ext;
    logic [TIME_BITS+FLD_TIME_W-1:0] w_min_ext;
    logic [CW+FLD_COUNT_W-1:0]       w_cnt_ext;
    logic [TIME_BITS-1:0] w_val [SET_DEPTH];
    logic [SET_DEPTH-1:0] w_lt;
    logic [SET_DEPTH-1:0] w_eq;
    logic [SET_DEPTH-1:0] w_occ;
    logic                 w_any_eq;
    t_cell_ctl            w_ctl;
    t_status              w_status;
    logic [CW-1:0]        w_count;

    // request time trimmed to the stored width
    assign w_t_ext = {{TIME_BITS{1'b0}}, i_req.time_value};

    // latch the item at acceptance
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_func <= i_req.func;
            r_t    <= w_t_ext[TIME_BITS-1:0];
        end
    end

    // sequencer
    sutset_ctrl #(
        .SET_DEPTH (SET_DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (r_func),
        .i_any_eq (w_any_eq),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_ctl    (w_ctl),
        .o_status (w_status),
        .o_count  (w_count)
    );

    // any slot holding the request time
    assign w_any_eq = |w_eq;

    // chain of cells, slot 0 holds the smallest time
    for (genvar gi = 0; gi < SET_DEPTH; gi++) begin : g_cell
        logic [TIME_BITS-1:0] w_left_val;
        logic                 w_left_lt;
        logic [TIME_BITS-1:0] w_right_val;

        assign w_occ[gi] = (w_count > CW'(gi));

        if (gi == 0) begin : g_head
            assign w_left_val = r_t;
            assign w_left_lt  = 1'b0;
        end else begin : g_body
            assign w_left_val = w_val[gi-1];
            assign w_left_lt  = w_lt[gi-1];
        end

        if (gi == SET_DEPTH - 1) begin : g_tail
            assign w_right_val = '0;
        end else begin : g_mid
            assign w_right_val = w_val[gi+1];
        end

        sutset_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_t         (r_t),
            .i_occ       (w_occ[gi]),
            .i_left_val  (w_left_val),
            .i_left_lt   (w_left_lt),
            .i_right_val (w_right_val),
            .o_val       (w_val[gi]),
            .o_lt        (w_lt[gi]),
            .o_eq        (w_eq[gi])
        );
    end

    // result fields
    assign w_min_ext = {{FLD_TIME_W{1'b0}}, w_val[0]};
    assign w_cnt_ext = {{FLD_COUNT_W{1'b0}}, w_count};

    always_comb begin
        o_rsp.status        = w_status;
        o_rsp.earliest_time = (w_count != '0) ? w_min_ext[FLD_TIME_W-1:0] : '0;
        o_rsp.entry_count   = w_cnt_ext[FLD_COUNT_W-1:0];
        o_rsp.is_empty      = (w_count == '0);
    end

endmodule : sorted_unique_time_set

`default_nettype wire

// ----- rtl/sutset_cell.sv -----
// sutset_cell: one slot of the sorted chain, holding a single stored time
// compares against the broadcast time and shifts with its neighbours
// depends on sutset_pkg
`timescale 1ns / 1ps
`default_nettype none

module sutset_cell
    import sutset_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  wire logic                 i_clk,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [TIME_BITS-1:0] i_t,
    input  wire logic                 i_occ,
    input  wire logic [TIME_BITS-1:0] i_left_val,
    input  wire logic                 i_left_lt,
    input  wire logic [TIME_BITS-1:0] i_right_val,
    output logic      [TIME_BITS-1:0] o_val,
    output logic                      o_lt,
    output logic                      o_eq
);

    logic [TIME_BITS-1:0] r_val;
    logic                 r_lt;
    logic                 r_eq;

    // compare flags, only meaningful for occupied slots
    always_ff @(posedge i_clk) begin
        if (i_ctl.flag_en) begin
            r_lt <= i_occ && (r_val < i_t);
            r_eq <= i_occ && (r_val == i_t);
        end
    end

    // slots at or above the insert/delete point shift by one
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en && !r_lt) begin
            r_val <= i_left_lt ? i_t : i_left_val;
        end else if (i_ctl.del_en && !r_lt) begin
            r_val <= i_right_val;
        end
    end

    assign o_val = r_val;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule : sutset_cell

`default_nettype wire

// ----- rtl/sutset_ctrl.sv -----
// sutset_ctrl: sequencer for compare and shift phases, entry count and status
// drives the cell control struct and the handshake
// depends on sutset_pkg
`timescale 1ns / 1ps
`default_nettype none

module sutset_ctrl
    import sutset_pkg::*;
#(
    parameter int SET_DEPTH = DEF_SET_DEPTH,
    localparam int CW       = $clog2(SET_DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_func,
    input  wire logic          i_any_eq,
    output logic               o_busy,
    output logic               o_done,
    output t_cell_ctl          o_ctl,
    output t_status            o_status,
    output logic      [CW-1:0] o_count
);

    t_state           r_state;
    t_state           n_state;
    logic    [CW-1:0] r_count;
    logic    [CW-1:0] n_count;
    t_status          r_status;
    t_status          n_status;
    logic             w_full;
    logic             w_ins_ok;
    logic             w_del_ok;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // status is held for the response cycle
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = S_CMP;
            S_CMP:   n_state = S_APPLY;
            S_APPLY: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // decision on the registered compare flags
    assign w_full   = (r_count == CW'(SET_DEPTH));
    assign w_ins_ok = (i_func == FUNC_INSERT) && !i_any_eq && !w_full;
    assign w_del_ok = (i_func == FUNC_DELETE) && i_any_eq;

    // outputs, count and status
    always_comb begin
        o_busy       = 1'b1;
        o_done       = 1'b0;
        o_ctl        = '0;
        n_count      = r_count;
        n_status     = r_status;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
            end
            S_CMP: begin
                o_ctl.flag_en = 1'b1;
            end
            S_APPLY: begin
                o_ctl.ins_en = w_ins_ok;
                o_ctl.del_en = w_del_ok;
                if (w_ins_ok) begin
                    n_count = r_count + CW'(1);
                end else if (w_del_ok) begin
                    n_count = r_count - CW'(1);
                end
                if (i_func == FUNC_INSERT) begin
                    if (i_any_eq)    n_status = ST_DUPLICATE;
                    else if (w_full) n_status = ST_FULL;
                    else             n_status = ST_INSERTED;
                end else begin
                    n_status = i_any_eq ? ST_DELETED : ST_NOT_FOUND;
                end
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    assign o_status = r_status;
    assign o_count  = r_count;

endmodule : sutset_ctrl

`default_nettype wire

// ----- tb/sorted_unique_time_set_test.sv -----
// sorted_unique_time_set_test: self-checking bench for the sorted time set
// mirrors the set in a local queue and checks every reply field by field
// depends on sutset_pkg and sorted_unique_time_set
`timescale 1ns / 1ps

module sorted_unique_time_set_test;
    import sutset_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam logic [FLD_TIME_W-1:0] TIME_MAX = {FLD_TIME_W{1'b1}};

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    // local copy of the stored times, ascending, and replies still owed
    logic [FLD_TIME_W-1:0] set_times[$];
    t_rsp                  replies_owed[$];

    int cycle_count    = 0;
    int mismatch_count = 0;
    int items_sent     = 0;
    int replies_seen   = 0;
    int status_seen[5] = '{default: 0};
    int burst_left     = 4;
    int peak_fill      = 0;

    sorted_unique_time_set u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies still owed",
                     cycle_count, replies_owed.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // apply one request to the local set and return the reply it earns
    function automatic t_rsp apply_to_set(input t_req req);
        t_rsp                  rsp;
        int                    pos;
        logic [FLD_TIME_W-1:0] t;
        t   = req.time_value;
        pos = 0;
        while (pos < set_times.size() && set_times[pos] < t)
            pos++;
        if (req.func == FUNC_INSERT) begin
            if (pos < set_times.size() && set_times[pos] == t) begin
                rsp.status = ST_DUPLICATE;
            end else if (set_times.size() >= DEF_SET_DEPTH) begin
                rsp.status = ST_FULL;
            end else begin
                set_times.insert(pos, t);
                rsp.status = ST_INSERTED;
            end
        end else begin
            if (pos >= set_times.size() || set_times[pos] != t) begin
                rsp.status = ST_NOT_FOUND;
            end else begin
                set_times.delete(pos);
                rsp.status = ST_DELETED;
            end
        end
        rsp.earliest_time = (set_times.size() > 0) ? set_times[0] : '0;
        rsp.entry_count   = FLD_COUNT_W'(set_times.size());
        rsp.is_empty      = (set_times.size() == 0);
        return rsp;
    endfunction

    // send one item, record its reply, then maybe pause between bursts
    task automatic send_item(input logic func, input logic [FLD_TIME_W-1:0] t);
        t_req req;
        req.func       = func;
        req.time_value = t;
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        replies_owed.push_back(apply_to_set(req));
        items_sent++;
        if (set_times.size() > peak_fill)
            peak_fill = set_times.size();
        burst_left--;
        if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on reply %0d, %s: expected %0h, got %0h",
                     replies_seen, what, exp_v, act_v);
    endtask

    // compare each reply with the oldest one owed
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done === 1'b1) begin
            if (replies_owed.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("reply with none owed: status %0d count %0d",
                             o_rsp.status, o_rsp.entry_count);
            end else begin
                want = replies_owed.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(o_rsp.status));
                if (o_rsp.earliest_time !== want.earliest_time)
                    report_mismatch("earliest_time", 32'(want.earliest_time),
                                    32'(o_rsp.earliest_time));
                if (o_rsp.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(want.entry_count),
                                    32'(o_rsp.entry_count));
                if (o_rsp.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(want.is_empty),
                                    32'(o_rsp.is_empty));
                if (want.status <= ST_FULL)
                    status_seen[want.status]++;
            end
            replies_seen++;
        end
    end

    // extremes, duplicates, deletes of absent times, empty store
    task automatic test_directed();
        send_item(FUNC_DELETE, '0);
        send_item(FUNC_INSERT, 31'd5);
        send_item(FUNC_INSERT, 31'd5);
        send_item(FUNC_INSERT, TIME_MAX);
        send_item(FUNC_INSERT, '0);
        send_item(FUNC_INSERT, TIME_MAX);
        send_item(FUNC_DELETE, 31'd3);
        send_item(FUNC_DELETE, '0);
        send_item(FUNC_DELETE, TIME_MAX);
        send_item(FUNC_DELETE, TIME_MAX);
        send_item(FUNC_INSERT, 31'h5555_5555);
        send_item(FUNC_INSERT, 31'h2AAA_AAAA);
        send_item(FUNC_INSERT, 31'd1);
        send_item(FUNC_DELETE, 31'd5);
        send_item(FUNC_DELETE, 31'h5555_5555);
        send_item(FUNC_DELETE, 31'h2AAA_AAAA);
        send_item(FUNC_DELETE, 31'd1);
        send_item(FUNC_DELETE, 31'd1);
    endtask

    // mixed inserts and deletes drawn from a small pool so hits are common
    task automatic test_churn(input int n);
        logic [FLD_TIME_W-1:0] pool[24];
        foreach (pool[k])
            pool[k] = FLD_TIME_W'($urandom);
        pool[0] = '0;
        pool[1] = TIME_MAX;
        repeat (n) begin
            send_item(($urandom_range(0, 9) < 6) ? FUNC_INSERT : FUNC_DELETE,
                      pool[$urandom_range(0, 23)]);
        end
    endtask

    // fill to capacity, push past it, then drain in random order
    task automatic test_fill_drain();
        int sel;
        logic [FLD_TIME_W-1:0] t;
        while (set_times.size() < DEF_SET_DEPTH)
            send_item(FUNC_INSERT, FLD_TIME_W'($urandom));
        repeat (3) send_item(FUNC_INSERT, FLD_TIME_W'($urandom));
        repeat (3) begin
            t = set_times[$urandom_range(0, set_times.size() - 1)];
            send_item(FUNC_INSERT, t);
        end
        while (set_times.size() > 0) begin
            sel = $urandom_range(0, 7);
            if (sel == 0) begin
                send_item(FUNC_DELETE, FLD_TIME_W'($urandom));
            end else if (sel == 1) begin
                send_item(FUNC_INSERT, FLD_TIME_W'($urandom));
            end else begin
                t = set_times[$urandom_range(0, set_times.size() - 1)];
                send_item(FUNC_DELETE, t);
            end
        end
    endtask

    // fully random items over the whole time range
    task automatic test_wide_random(input int n);
        repeat (n)
            send_item(($urandom_range(0, 3) == 0) ? FUNC_DELETE : FUNC_INSERT,
                      FLD_TIME_W'($urandom));
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_churn(180);
        test_fill_drain();
        test_wide_random(60);
        test_churn(40);

        // let the last replies arrive
        start <= 1'b0;
        while (replies_owed.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d items sent, %0d replies checked, set filled to %0d of %0d",
                 items_sent, replies_seen, peak_fill, DEF_SET_DEPTH);
        $display("inserted %0d, duplicate %0d, deleted %0d, not found %0d, full %0d",
                 status_seen[ST_INSERTED], status_seen[ST_DUPLICATE],
                 status_seen[ST_DELETED], status_seen[ST_NOT_FOUND],
                 status_seen[ST_FULL]);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sutset_pkg.sv
rtl/sutset_cell.sv
rtl/sutset_ctrl.sv
rtl/sorted_unique_time_set.sv
tb/sorted_unique_time_set_test.sv
